// ===== rtl/core/esc_pkg.sv =====
// ============================================================================
// esc_pkg: shared constants and helpers for the sensor compensation core
// Fixed-point constants, register indexes and 32-bit wrap arithmetic helpers.
// ============================================================================
package esc_pkg;

    localparam int unsigned DIV_W = 32;

    localparam logic [31:0] TFINE_P_OFS  = 32'd64000;
    localparam logic [31:0] PRESS_BASE   = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE  = 32'd3125;
    localparam logic [31:0] TFINE_H_OFS  = 32'd76800;
    localparam logic [31:0] HUM_ROUND    = 32'd16384;
    localparam logic [31:0] HUM_BIAS     = 32'd2097152;
    localparam logic [31:0] HUM_ACC_MAX  = 32'd419430400;

    typedef enum logic [2:0] {
        REG_TEMP_CALIB   = 3'd0,
        REG_PRESS_LOW    = 3'd1,
        REG_PRESS_HIGH   = 3'd2,
        REG_PRESS_HUMID  = 3'd3,
        REG_HUMID_REST   = 3'd4
    } reg_idx_t;

    // low 32 bits of a product; same bits for signed or unsigned operands
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        r = a * b;
        return r;
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        logic [31:0] r;
        r = $unsigned($signed(x) >>> n);
        return r;
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

endpackage

// ===== rtl/core/esc_divider.sv =====
// ============================================================================
// esc_divider: pipelined restoring divider
// One quotient bit per stage, DIV_W stages, sideband travels with each item.
// ============================================================================
module esc_divider
    import esc_pkg::*;
#(
    parameter int unsigned DIV_W  = esc_pkg::DIV_W,
    parameter int unsigned SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DIV_W-1:0]  num,
    input  logic [DIV_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [DIV_W-1:0]  quot,
    output logic [SIDE_W-1:0] side_out
);

    logic [DIV_W-1:0]  rem_reg  [DIV_W];
    logic [DIV_W-1:0]  nq_reg   [DIV_W];
    logic [DIV_W-1:0]  den_reg  [DIV_W];
    logic [SIDE_W-1:0] side_reg [DIV_W];
    logic [DIV_W-1:0]  v_reg;
    logic [DIV_W-1:0]  rem_next [DIV_W];
    logic [DIV_W-1:0]  nq_next  [DIV_W];

    genvar g;
    generate
        for (g = 0; g < DIV_W; g++) begin : g_stage
            logic [DIV_W-1:0]  rem_in;
            logic [DIV_W-1:0]  nq_in;
            logic [DIV_W-1:0]  den_in;
            logic [DIV_W:0]    trial;
            logic [DIV_W-1:0]  rem_st;
            logic [DIV_W-1:0]  nq_st;

            if (g == 0) begin : g_first
                assign rem_in = '0;
                assign nq_in  = num;
                assign den_in = den;
            end
            else begin : g_rest
                assign rem_in = rem_reg[g-1];
                assign nq_in  = nq_reg[g-1];
                assign den_in = den_reg[g-1];
            end

            always_comb
            begin
                trial = {rem_in, nq_in[DIV_W-1]} - {1'b0, den_in};
                if (!trial[DIV_W])
                begin
                    rem_st = trial[DIV_W-1:0];
                    nq_st  = {nq_in[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_st = {rem_in[DIV_W-2:0], nq_in[DIV_W-1]};
                    nq_st  = {nq_in[DIV_W-2:0], 1'b0};
                end
            end

            assign rem_next[g] = rem_st;
            assign nq_next[g]  = nq_st;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DIV_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            for (int i = 0; i < DIV_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                nq_reg[i]  <= nq_next[i];
            end
            for (int i = 1; i < DIV_W; i++)
            begin
                den_reg[i]  <= den_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[DIV_W-1];
    assign quot      = nq_reg[DIV_W-1];
    assign side_out  = side_reg[DIV_W-1];

endmodule

// ===== rtl/core/env_sensor_compensation_core.sv =====
// ============================================================================
// env_sensor_compensation_core: temperature/pressure/humidity compensation
// Integer compensation of one raw reading set per item, fully pipelined.
// ============================================================================
// Path from input accept to output valid: 12 front stages,
//   32 divider stages, 3 pressure trim stages incl. the output register.
// Throughput: one item per cycle; a single pipeline-wide enable stalls all
//   stages while the output register holds an item not yet taken.
// Reset: rst_n async active low clears all valid bits and the calibration
//   registers; payload registers are not reset.
module env_sensor_compensation_core
    import esc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // APB-style configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    // input item channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    input  logic [15:0]        raw_humidity,
    // result item channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] temperature_centi,
    output logic [31:0]        pressure_pa,
    output logic               pressure_valid,
    output logic [16:0]        humidity_q10
);

    // sideband through the divider: flag, nonzero, temperature, humidity
    localparam int unsigned SIDE_W = 1 + 1 + 16 + 17;

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [47:0] temp_calib_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [47:0] press_humid_reg;
    logic [39:0] humid_rest_reg;
    logic        wr_en;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg  <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_humid_reg <= '0;
            humid_rest_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (widx)
                REG_TEMP_CALIB:  temp_calib_reg  <= pwdata[47:0];
                REG_PRESS_LOW:   press_low_reg   <= pwdata;
                REG_PRESS_HIGH:  press_high_reg  <= pwdata;
                REG_PRESS_HUMID: press_humid_reg <= pwdata[47:0];
                REG_HUMID_REST:  humid_rest_reg  <= pwdata[39:0];
                default: ;  // unmapped address: write dropped
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_TEMP_CALIB:  prdata = {16'd0, temp_calib_reg};
            REG_PRESS_LOW:   prdata = press_low_reg;
            REG_PRESS_HIGH:  prdata = press_high_reg;
            REG_PRESS_HUMID: prdata = {16'd0, press_humid_reg};
            REG_HUMID_REST:  prdata = {24'd0, humid_rest_reg};
            default:         prdata = '0;
        endcase
    end

    // coefficient unpack, all extended to 32 bits
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    assign t1 = {16'd0, temp_calib_reg[15:0]};
    assign t2 = sx16(temp_calib_reg[31:16]);
    assign t3 = sx16(temp_calib_reg[47:32]);
    assign p1 = {16'd0, press_low_reg[15:0]};
    assign p2 = sx16(press_low_reg[31:16]);
    assign p3 = sx16(press_low_reg[47:32]);
    assign p4 = sx16(press_low_reg[63:48]);
    assign p5 = sx16(press_high_reg[15:0]);
    assign p6 = sx16(press_high_reg[31:16]);
    assign p7 = sx16(press_high_reg[47:32]);
    assign p8 = sx16(press_high_reg[63:48]);
    assign p9 = sx16(press_humid_reg[15:0]);
    assign h1 = {24'd0, press_humid_reg[23:16]};
    assign h2 = sx16(press_humid_reg[39:24]);
    assign h3 = {24'd0, press_humid_reg[47:40]};
    assign h4 = sx16(humid_rest_reg[15:0]);
    assign h5 = sx16(humid_rest_reg[31:16]);
    assign h6 = sx8(humid_rest_reg[39:32]);

    // ------------------------------------------------------------------
    // Pipeline control: one enable for every stage
    // ------------------------------------------------------------------
    logic        en;
    logic [12:1] v_reg;
    logic        div_v;
    logic        q1_v_reg, q2_v_reg;
    logic        out_v_reg;

    assign en        = !out_v_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            q1_v_reg  <= 1'b0;
            q2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[11:1], in_valid};
            q1_v_reg  <= div_v;
            q2_v_reg  <= q1_v_reg;
            out_v_reg <= q2_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Front stages: temperature, pressure divisor/dividend, humidity
    // ------------------------------------------------------------------
    logic [31:0] s1_ta_reg, s1_d_reg;
    logic [19:0] s1_adcp_reg, s2_adcp_reg, s3_adcp_reg, s4_adcp_reg;
    logic [19:0] s5_adcp_reg, s6_adcp_reg, s7_adcp_reg, s8_adcp_reg;
    logic [15:0] s1_adch_reg, s2_adch_reg, s3_adch_reg, s4_adch_reg, s5_adch_reg;
    logic [31:0] s2_m1_reg, s2_dd_reg;
    logic [31:0] s3_a_reg, s3_m2_reg;
    logic [31:0] s4_tfine_reg;
    logic [31:0] s5_tc5_reg, s5_pa_reg, s5_ha_reg;
    logic [15:0] s6_temp_reg, s7_temp_reg, s8_temp_reg, s9_temp_reg;
    logic [15:0] s10_temp_reg, s11_temp_reg, s12_temp_reg;
    logic [31:0] s6_q1_reg, s6_q2_reg, s6_q3_reg, s6_hx_reg, s6_hb_reg, s6_hc_reg;
    logic [31:0] s7_r1_reg, s7_r2_reg, s7_q2_reg, s7_q3_reg, s7_hd_reg, s7_hm_reg;
    logic [31:0] s8_b_reg, s8_a_reg, s8_hm2_reg, s8_hd_reg;
    logic [31:0] s9_a2_reg, s9_pb_reg, s9_ha_reg;
    logic [31:0] s10_p_reg, s10_den_reg, s10_hsq_reg, s10_ha_reg;
    logic [31:0] s11_num_reg, s11_den_reg, s11_ht_reg, s11_ha_reg;
    logic        s11_flag_reg, s12_flag_reg;
    logic [31:0] s12_num_reg, s12_den_reg;
    logic [16:0] s12_hum_reg;

    logic [31:0] s1_ta_next, s1_d_next;
    logic [31:0] s5_tc5_next;
    logic [31:0] tc;
    logic [15:0] s6_temp_next;
    logic [31:0] pd;
    logic [31:0] s8_b_next, s8_a_next;
    logic [31:0] hum_acc;
    logic [16:0] s12_hum_next;

    always_comb
    begin
        s1_ta_next = ({12'd0, raw_temperature} >> 3) - (t1 << 1);
        s1_d_next  = ({12'd0, raw_temperature} >> 4) - t1;

        s5_tc5_next = (s4_tfine_reg << 2) + s4_tfine_reg + 32'd128;

        // temperature saturate to int16
        tc = asr32(s5_tc5_reg, 8);
        if (tc[31])
            s6_temp_next = (tc[31:15] != '1) ? 16'h8000 : tc[15:0];
        else
            s6_temp_next = (tc[31:15] != '0) ? 16'h7FFF : tc[15:0];

        pd = asr32(s5_pa_reg, 2);

        s8_b_next = asr32(s7_r1_reg + (s7_q2_reg << 1), 2) + (p4 << 16);
        s8_a_next = asr32(asr32(s7_r2_reg, 3) + asr32(s7_q3_reg, 1), 18) + 32'd32768;

        // humidity clamp to 0..HUM_ACC_MAX, then Q7.10
        hum_acc = s11_ha_reg - asr32(s11_ht_reg, 4);
        if (hum_acc[31])
            hum_acc = '0;
        else if (hum_acc > HUM_ACC_MAX)
            hum_acc = HUM_ACC_MAX;
        s12_hum_next = hum_acc[28:12];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // S1
            s1_ta_reg   <= s1_ta_next;
            s1_d_reg    <= s1_d_next;
            s1_adcp_reg <= raw_pressure;
            s1_adch_reg <= raw_humidity;
            // S2
            s2_m1_reg   <= mul32(s1_ta_reg, t2);
            s2_dd_reg   <= mul32(s1_d_reg, s1_d_reg);
            s2_adcp_reg <= s1_adcp_reg;
            s2_adch_reg <= s1_adch_reg;
            // S3
            s3_a_reg    <= asr32(s2_m1_reg, 11);
            s3_m2_reg   <= mul32(asr32(s2_dd_reg, 12), t3);
            s3_adcp_reg <= s2_adcp_reg;
            s3_adch_reg <= s2_adch_reg;
            // S4: fine temperature
            s4_tfine_reg <= s3_a_reg + asr32(s3_m2_reg, 14);
            s4_adcp_reg  <= s3_adcp_reg;
            s4_adch_reg  <= s3_adch_reg;
            // S5
            s5_tc5_reg  <= s5_tc5_next;
            s5_pa_reg   <= asr32(s4_tfine_reg, 1) - TFINE_P_OFS;
            s5_ha_reg   <= s4_tfine_reg - TFINE_H_OFS;
            s5_adcp_reg <= s4_adcp_reg;
            s5_adch_reg <= s4_adch_reg;
            // S6
            s6_temp_reg <= s6_temp_next;
            s6_q1_reg   <= mul32(pd, pd);
            s6_q2_reg   <= mul32(s5_pa_reg, p5);
            s6_q3_reg   <= mul32(p2, s5_pa_reg);
            s6_hx_reg   <= ({16'd0, s5_adch_reg} << 14) - (h4 << 20)
                           - mul32(h5, s5_ha_reg);
            s6_hb_reg   <= mul32(s5_ha_reg, h6);
            s6_hc_reg   <= mul32(s5_ha_reg, h3);
            s6_adcp_reg <= s5_adcp_reg;
            // S7
            s7_temp_reg <= s6_temp_reg;
            s7_r1_reg   <= mul32(asr32(s6_q1_reg, 11), p6);
            s7_r2_reg   <= mul32(p3, asr32(s6_q1_reg, 13));
            s7_q2_reg   <= s6_q2_reg;
            s7_q3_reg   <= s6_q3_reg;
            s7_hd_reg   <= asr32(s6_hx_reg + HUM_ROUND, 15);
            s7_hm_reg   <= mul32(asr32(s6_hb_reg, 10),
                                 asr32(s6_hc_reg, 11) + 32'd32768);
            s7_adcp_reg <= s6_adcp_reg;
            // S8
            s8_temp_reg <= s7_temp_reg;
            s8_b_reg    <= s8_b_next;
            s8_a_reg    <= s8_a_next;
            s8_hm2_reg  <= mul32(asr32(s7_hm_reg, 10) + HUM_BIAS, h2);
            s8_hd_reg   <= s7_hd_reg;
            s8_adcp_reg <= s7_adcp_reg;
            // S9: divisor and dividend base
            s9_temp_reg <= s8_temp_reg;
            s9_a2_reg   <= asr32(mul32(s8_a_reg, p1), 15);
            s9_pb_reg   <= (PRESS_BASE - {12'd0, s8_adcp_reg}) - asr32(s8_b_reg, 12);
            s9_ha_reg   <= mul32(s8_hd_reg, asr32(s8_hm2_reg + 32'd8192, 14));
            // S10
            s10_temp_reg <= s9_temp_reg;
            s10_p_reg    <= mul32(s9_pb_reg, PRESS_SCALE);
            s10_den_reg  <= s9_a2_reg;
            s10_hsq_reg  <= mul32(asr32(s9_ha_reg, 15), asr32(s9_ha_reg, 15));
            s10_ha_reg   <= s9_ha_reg;
            // S11: dividend prescale; large values divide first, double after
            s11_temp_reg <= s10_temp_reg;
            s11_flag_reg <= s10_p_reg[31];
            s11_num_reg  <= s10_p_reg[31] ? s10_p_reg : (s10_p_reg << 1);
            s11_den_reg  <= s10_den_reg;
            s11_ht_reg   <= mul32(asr32(s10_hsq_reg, 7), h1);
            s11_ha_reg   <= s10_ha_reg;
            // S12
            s12_temp_reg <= s11_temp_reg;
            s12_flag_reg <= s11_flag_reg;
            s12_num_reg  <= s11_num_reg;
            s12_den_reg  <= s11_den_reg;
            s12_hum_reg  <= s12_hum_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] side_in, side_out;
    logic [31:0]       quot;

    assign side_in = {s12_flag_reg, (s12_den_reg != '0), s12_temp_reg, s12_hum_reg};

    esc_divider #(
        .DIV_W  (DIV_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[12]),
        .num       (s12_num_reg),
        .den       (s12_den_reg),
        .side_in   (side_in),
        .out_valid (div_v),
        .quot      (quot),
        .side_out  (side_out)
    );

    // ------------------------------------------------------------------
    // Pressure trim stages
    // ------------------------------------------------------------------
    logic [31:0] q1_p_reg, q1_sq_reg, q1_pb_reg;
    logic [31:0] q2_p_reg, q2_m_reg, q2_b_reg;
    logic        q1_nz_reg, q2_nz_reg;
    logic [15:0] q1_temp_reg, q2_temp_reg;
    logic [16:0] q1_hum_reg, q2_hum_reg;
    logic [31:0] pfix;
    logic [31:0] press_next;

    logic signed [15:0] temp_out_reg;
    logic [31:0]        press_out_reg;
    logic               pvalid_out_reg;
    logic [16:0]        hum_out_reg;

    always_comb
    begin
        pfix = side_out[34] ? (quot << 1) : quot;
        press_next = q2_p_reg + asr32(asr32(q2_m_reg, 12) + q2_b_reg + p7, 4);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_p_reg    <= pfix;
            q1_sq_reg   <= mul32(pfix >> 3, pfix >> 3);
            q1_pb_reg   <= mul32(pfix >> 2, p8);
            q1_nz_reg   <= side_out[33];
            q1_temp_reg <= side_out[32:17];
            q1_hum_reg  <= side_out[16:0];

            q2_p_reg    <= q1_p_reg;
            q2_m_reg    <= mul32(p9, q1_sq_reg >> 13);
            q2_b_reg    <= asr32(q1_pb_reg, 13);
            q2_nz_reg   <= q1_nz_reg;
            q2_temp_reg <= q1_temp_reg;
            q2_hum_reg  <= q1_hum_reg;

            temp_out_reg   <= $signed(q2_temp_reg);
            press_out_reg  <= q2_nz_reg ? press_next : '0;
            pvalid_out_reg <= q2_nz_reg;
            hum_out_reg    <= q2_hum_reg;
        end
    end

    assign temperature_centi = temp_out_reg;
    assign pressure_pa       = press_out_reg;
    assign pressure_valid    = pvalid_out_reg;
    assign humidity_q10      = hum_out_reg;

`ifndef SYNTH
    // a zero divisor must never leak a quotient
    a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pressure_valid) |-> (pressure_pa == 32'd0))
        else $error("pressure_pa nonzero with pressure_valid low");

    // humidity clamp holds at the output
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (humidity_q10 <= 17'd102400))
        else $error("humidity_q10 above 100 percent");

    // a stall freezes the front valid bits and the output
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v_reg) && $stable(out_v_reg)))
        else $error("pipeline moved during stall");
`endif

endmodule
